// ----- sv/stl_pkg.sv -----
// shared types, constants and helper functions for the source text lexer
// no dependencies; imported by every other file of the block
`timescale 1ns / 1ps

package stl_pkg;

  localparam int POS_BITS      = 20;
  localparam int FIELD_BITS    = 20;
  localparam int CHAR_BITS     = 8;
  localparam int KEYWORD_CHARS = 6;
  localparam int KW_BITS       = KEYWORD_CHARS * CHAR_BITS;
  localparam int KW_COUNT      = 15;
  localparam int MAX_TOKENS    = 3;
  localparam int CNT_BITS      = $clog2(MAX_TOKENS + 1);
  localparam int KIND_BITS     = 6;

  typedef logic [POS_BITS-1:0]  pos_t;
  typedef logic [CHAR_BITS-1:0] char_t;
  typedef logic [KIND_BITS-1:0] tkind_t;

  // input word kinds
  localparam logic IN_BYTE = 1'b0;
  localparam logic IN_END  = 1'b1;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUM,
    MODE_NUMDOT,
    MODE_FLOAT,
    MODE_STR,
    MODE_COMMENT,
    MODE_MINUS,
    MODE_EQ,
    MODE_BANG,
    MODE_GT,
    MODE_LT,
    MODE_SLASH
  } stl_mode_e;

  // token kinds
  localparam tkind_t TK_LET    = 6'd0;
  localparam tkind_t TK_OUT    = 6'd1;
  localparam tkind_t TK_IN     = 6'd2;
  localparam tkind_t TK_IF     = 6'd3;
  localparam tkind_t TK_ELIF   = 6'd4;
  localparam tkind_t TK_ELSE   = 6'd5;
  localparam tkind_t TK_MOD    = 6'd6;
  localparam tkind_t TK_INT_KW = 6'd7;
  localparam tkind_t TK_DOUBLE = 6'd8;
  localparam tkind_t TK_STRING = 6'd9;
  localparam tkind_t TK_BOOL   = 6'd10;
  localparam tkind_t TK_BOOLV  = 6'd11;
  localparam tkind_t TK_AND    = 6'd12;
  localparam tkind_t TK_OR     = 6'd13;
  localparam tkind_t TK_IDENT  = 6'd14;
  localparam tkind_t TK_INT    = 6'd15;
  localparam tkind_t TK_DEC    = 6'd16;
  localparam tkind_t TK_STR    = 6'd17;
  localparam tkind_t TK_EOL    = 6'd18;
  localparam tkind_t TK_EOF    = 6'd19;
  localparam tkind_t TK_UNK    = 6'd20;
  localparam tkind_t TK_PLUS   = 6'd21;
  localparam tkind_t TK_MINUS  = 6'd22;
  localparam tkind_t TK_ARROW  = 6'd23;
  localparam tkind_t TK_STAR   = 6'd24;
  localparam tkind_t TK_SLASH  = 6'd25;
  localparam tkind_t TK_ASSIGN = 6'd26;
  localparam tkind_t TK_EQEQ   = 6'd27;
  localparam tkind_t TK_BANG   = 6'd28;
  localparam tkind_t TK_NE     = 6'd29;
  localparam tkind_t TK_GT     = 6'd30;
  localparam tkind_t TK_GE     = 6'd31;
  localparam tkind_t TK_LT     = 6'd32;
  localparam tkind_t TK_LE     = 6'd33;
  localparam tkind_t TK_LARROW = 6'd34;
  localparam tkind_t TK_SEMI   = 6'd35;
  localparam tkind_t TK_LPAREN = 6'd36;
  localparam tkind_t TK_RPAREN = 6'd37;
  localparam tkind_t TK_LBRACE = 6'd38;
  localparam tkind_t TK_RBRACE = 6'd39;
  localparam tkind_t TK_COMMA  = 6'd40;
  localparam tkind_t NO_PAIR   = TK_UNK;

  // character codes
  localparam char_t CH_TAB    = 8'h09;
  localparam char_t CH_NL     = 8'h0A;
  localparam char_t CH_VT     = 8'h0B;
  localparam char_t CH_FF     = 8'h0C;
  localparam char_t CH_CR     = 8'h0D;
  localparam char_t CH_SPACE  = 8'h20;
  localparam char_t CH_BANG   = 8'h21;
  localparam char_t CH_QUOTE  = 8'h22;
  localparam char_t CH_LPAREN = 8'h28;
  localparam char_t CH_RPAREN = 8'h29;
  localparam char_t CH_STAR   = 8'h2A;
  localparam char_t CH_PLUS   = 8'h2B;
  localparam char_t CH_COMMA  = 8'h2C;
  localparam char_t CH_MINUS  = 8'h2D;
  localparam char_t CH_DOT    = 8'h2E;
  localparam char_t CH_SLASH  = 8'h2F;
  localparam char_t CH_D0     = 8'h30;
  localparam char_t CH_D9     = 8'h39;
  localparam char_t CH_SEMI   = 8'h3B;
  localparam char_t CH_LT     = 8'h3C;
  localparam char_t CH_EQ     = 8'h3D;
  localparam char_t CH_GT     = 8'h3E;
  localparam char_t CH_UA     = 8'h41;
  localparam char_t CH_UZ     = 8'h5A;
  localparam char_t CH_USCORE = 8'h5F;
  localparam char_t CH_LA     = 8'h61;
  localparam char_t CH_LZ     = 8'h7A;
  localparam char_t CH_LBRACE = 8'h7B;
  localparam char_t CH_RBRACE = 8'h7D;

  // keyword table, words right-aligned with zero fill
  localparam logic [KW_BITS-1:0] KW_WORD [KW_COUNT] = '{
    "let", "out", "in", "if", "elif", "else", "mod", "int",
    "double", "string", "bool", "true", "false", "and", "or"
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd3, 4'd2, 4'd2, 4'd4, 4'd4, 4'd3, 4'd3,
    4'd6, 4'd6, 4'd4, 4'd4, 4'd5, 4'd3, 4'd2
  };
  localparam tkind_t KW_KIND [KW_COUNT] = '{
    TK_LET, TK_OUT, TK_IN, TK_IF, TK_ELIF, TK_ELSE, TK_MOD, TK_INT_KW,
    TK_DOUBLE, TK_STRING, TK_BOOL, TK_BOOLV, TK_BOOLV, TK_AND, TK_OR
  };

  typedef struct packed {
    tkind_t                kind;
    logic [FIELD_BITS-1:0] line;
    logic [FIELD_BITS-1:0] column;
    logic [FIELD_BITS-1:0] offset;
    logic [FIELD_BITS-1:0] length;
  } stl_token_t;

  // the tokens caused by one input word, in order
  typedef struct packed {
    stl_token_t [MAX_TOKENS-1:0] tok;
    logic [CNT_BITS-1:0]         count;
  } stl_group_t;

  function automatic pos_t sat_inc(input pos_t v);
    return (v != '1) ? v + POS_BITS'(1) : v;
  endfunction

  function automatic logic is_digit(input char_t c);
    return (c >= CH_D0) && (c <= CH_D9);
  endfunction

  function automatic logic is_alpha(input char_t c);
    return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
  endfunction

  function automatic logic is_word(input char_t c);
    return is_alpha(c) || is_digit(c) || (c == CH_USCORE);
  endfunction

  function automatic logic is_blank(input char_t c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) ||
           (c == CH_CR);
  endfunction

  function automatic tkind_t kw_lookup(input logic [KW_BITS-1:0] kw_v, input pos_t run);
    tkind_t k;
    k = TK_IDENT;
    if (run <= POS_BITS'(KEYWORD_CHARS)) begin
      for (int i = 0; i < KW_COUNT; i++) begin
        if ((kw_v == KW_WORD[i]) && (run == POS_BITS'(KW_LEN[i]))) begin
          k = KW_KIND[i];
        end
      end
    end
    return k;
  endfunction

  function automatic tkind_t single_kind(input stl_mode_e m);
    tkind_t k;
    unique case (m)
      MODE_MINUS: k = TK_MINUS;
      MODE_EQ:    k = TK_ASSIGN;
      MODE_BANG:  k = TK_BANG;
      MODE_GT:    k = TK_GT;
      MODE_LT:    k = TK_LT;
      default:    k = TK_SLASH;
    endcase
    return k;
  endfunction

  function automatic tkind_t pair_kind(input stl_mode_e m, input char_t c);
    tkind_t k;
    k = NO_PAIR;
    unique case (m)
      MODE_MINUS: if (c == CH_GT) k = TK_ARROW;
      MODE_EQ:    if (c == CH_EQ) k = TK_EQEQ;
      MODE_BANG:  if (c == CH_EQ) k = TK_NE;
      MODE_GT:    if (c == CH_EQ) k = TK_GE;
      MODE_LT: begin
        if (c == CH_EQ) begin
          k = TK_LE;
        end else if (c == CH_MINUS) begin
          k = TK_LARROW;
        end
      end
      default: k = NO_PAIR;
    endcase
    return k;
  endfunction

  // tokens that a lone byte gives at once
  function automatic tkind_t char_kind(input char_t c);
    tkind_t k;
    unique case (c)
      CH_NL:     k = TK_EOL;
      CH_PLUS:   k = TK_PLUS;
      CH_STAR:   k = TK_STAR;
      CH_SEMI:   k = TK_SEMI;
      CH_LPAREN: k = TK_LPAREN;
      CH_RPAREN: k = TK_RPAREN;
      CH_LBRACE: k = TK_LBRACE;
      CH_RBRACE: k = TK_RBRACE;
      CH_COMMA:  k = TK_COMMA;
      default:   k = TK_UNK;
    endcase
    return k;
  endfunction

  // bytes that open a pending token
  function automatic logic starts_token(input char_t c);
    return is_digit(c) || is_alpha(c) || (c == CH_USCORE) || (c == CH_QUOTE) ||
           (c == CH_MINUS) || (c == CH_EQ) || (c == CH_BANG) || (c == CH_GT) ||
           (c == CH_LT) || (c == CH_SLASH);
  endfunction

endpackage

// ----- sv/stl_if.sv -----
// valid/ready channel interfaces: source bytes in, tokens out
// depends on stl_pkg
`timescale 1ns / 1ps

interface stl_char_if import stl_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        kind;
  char_t       char_byte;

  modport source (output valid, output kind, output char_byte, input ready);
  modport sink   (input valid, input kind, input char_byte, output ready);
endinterface

interface stl_token_if import stl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  tkind_t                token_kind;
  logic [FIELD_BITS-1:0] token_line;
  logic [FIELD_BITS-1:0] token_column;
  logic [FIELD_BITS-1:0] token_offset;
  logic [FIELD_BITS-1:0] token_length;
  logic                  last;

  modport source (output valid, output token_kind, output token_line, output token_column,
                  output token_offset, output token_length, output last, input ready);
  modport sink   (input valid, input token_kind, input token_line, input token_column,
                  input token_offset, input token_length, input last, output ready);
endinterface

// ----- sv/stl_scan_core.sv -----
// scan state machine: position counters, pending token and keyword buffer,
// plus the logic that turns one word into up to three tokens; depends on stl_pkg
`timescale 1ns / 1ps

module stl_scan_core import stl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       kind_i,
  input  char_t      byte_i,
  output stl_group_t group_o
);

  stl_mode_e          mode_q, mode_d;
  pos_t               line_q, line_d;
  pos_t               col_q, col_d;
  pos_t               pos_q, pos_d;
  pos_t               soff_q, soff_d;
  pos_t               scol_q, scol_d;
  pos_t               run_q, run_d;
  logic [KW_BITS-1:0] kwb_q, kwb_d;

  logic       is_end;
  logic       used;
  tkind_t     pair;
  logic       pend_a, pend_b, pend_c;
  stl_token_t tok_a, tok_b, tok_c;

  assign is_end = (kind_i == IN_END);
  assign pair   = pair_kind(mode_q, byte_i);

  // does the pending token swallow this byte
  always_comb begin
    used = 1'b0;
    if (!is_end) begin
      unique case (mode_q)
        MODE_IDENT:   used = is_word(byte_i);
        MODE_NUM:     used = is_digit(byte_i) || (byte_i == CH_DOT);
        MODE_NUMDOT:  used = is_digit(byte_i);
        MODE_FLOAT:   used = is_digit(byte_i);
        MODE_STR:     used = 1'b1;
        MODE_COMMENT: used = (byte_i != CH_NL);
        MODE_IDLE:    used = 1'b0;
        MODE_SLASH:   used = (byte_i == CH_SLASH);
        default:      used = (pair != NO_PAIR);
      endcase
    end
  end

  // next state
  always_comb begin
    mode_d = mode_q;
    line_d = line_q;
    col_d  = col_q;
    pos_d  = pos_q;
    soff_d = soff_q;
    scol_d = scol_q;
    run_d  = run_q;
    kwb_d  = kwb_q;
    if (is_end) begin
      mode_d = MODE_IDLE;
      line_d = POS_BITS'(1);
      col_d  = POS_BITS'(1);
      pos_d  = '0;
      soff_d = '0;
      scol_d = POS_BITS'(1);
      run_d  = '0;
      kwb_d  = '0;
    end else begin
      unique case (mode_q)
        MODE_IDENT: begin
          if (used) begin
            if (run_q < POS_BITS'(KEYWORD_CHARS)) begin
              kwb_d = {kwb_q[KW_BITS-CHAR_BITS-1:0], byte_i};
            end
            run_d = sat_inc(run_q);
          end else begin
            mode_d = MODE_IDLE;
          end
        end
        MODE_NUM: begin
          if (is_digit(byte_i)) begin
            run_d = sat_inc(run_q);
          end else if (byte_i == CH_DOT) begin
            mode_d = MODE_NUMDOT;
          end else begin
            mode_d = MODE_IDLE;
          end
        end
        MODE_NUMDOT: begin
          if (used) begin
            run_d  = sat_inc(sat_inc(run_q));
            mode_d = MODE_FLOAT;
          end else begin
            mode_d = MODE_IDLE;
          end
        end
        MODE_FLOAT: begin
          if (used) begin
            run_d = sat_inc(run_q);
          end else begin
            mode_d = MODE_IDLE;
          end
        end
        MODE_STR: begin
          if (byte_i == CH_QUOTE) begin
            mode_d = MODE_IDLE;
          end else begin
            run_d = sat_inc(run_q);
          end
        end
        MODE_COMMENT: begin
          if (!used) mode_d = MODE_IDLE;
        end
        MODE_IDLE: mode_d = MODE_IDLE;
        default: begin
          mode_d = (mode_q == MODE_SLASH && used) ? MODE_COMMENT : MODE_IDLE;
        end
      endcase

      // byte not taken by a pending token may open a new one
      if (!used && !is_blank(byte_i) && (byte_i != CH_NL)) begin
        soff_d = pos_q;
        scol_d = col_q;
        if (is_digit(byte_i)) begin
          mode_d = MODE_NUM;
          run_d  = POS_BITS'(1);
        end else if (is_alpha(byte_i) || (byte_i == CH_USCORE)) begin
          mode_d = MODE_IDENT;
          kwb_d  = KW_BITS'(byte_i);
          run_d  = POS_BITS'(1);
        end else begin
          unique case (byte_i)
            CH_QUOTE: begin
              mode_d = MODE_STR;
              soff_d = sat_inc(pos_q);
              run_d  = '0;
            end
            CH_MINUS: mode_d = MODE_MINUS;
            CH_EQ:    mode_d = MODE_EQ;
            CH_BANG:  mode_d = MODE_BANG;
            CH_GT:    mode_d = MODE_GT;
            CH_LT:    mode_d = MODE_LT;
            CH_SLASH: mode_d = MODE_SLASH;
            default:  mode_d = MODE_IDLE;
          endcase
        end
      end

      if (byte_i == CH_NL) begin
        line_d = sat_inc(line_q);
        col_d  = POS_BITS'(1);
      end else begin
        col_d = sat_inc(col_q);
      end
      pos_d = sat_inc(pos_q);
    end
  end

  // tokens of this word
  always_comb begin
    // a two-char operator closes its pending token on the second byte
    pend_a = (mode_q != MODE_IDLE) && (mode_q != MODE_COMMENT) &&
             (is_end || !used || (pair != NO_PAIR) ||
              (mode_q == MODE_STR && byte_i == CH_QUOTE));
    pend_b = pend_a && (mode_q == MODE_NUMDOT);
    pend_c = is_end || (!used && !is_blank(byte_i) && !starts_token(byte_i));

    tok_a.line   = FIELD_BITS'(line_q);
    tok_a.column = FIELD_BITS'(scol_q);
    tok_a.offset = FIELD_BITS'(soff_q);
    tok_a.length = FIELD_BITS'(run_q);
    unique case (mode_q)
      MODE_IDENT:  tok_a.kind = kw_lookup(kwb_q, run_q);
      MODE_NUM:    tok_a.kind = TK_INT;
      MODE_NUMDOT: tok_a.kind = TK_INT;
      MODE_FLOAT:  tok_a.kind = TK_DEC;
      MODE_STR:    tok_a.kind = TK_STR;
      MODE_IDLE, MODE_COMMENT: tok_a.kind = TK_UNK;
      default: begin
        tok_a.kind   = used ? pair : single_kind(mode_q);
        tok_a.length = used ? FIELD_BITS'(2) : FIELD_BITS'(1);
      end
    endcase

    // the point that led no fraction
    tok_b.kind   = TK_UNK;
    tok_b.line   = FIELD_BITS'(line_q);
    tok_b.column = FIELD_BITS'((col_q > POS_BITS'(1)) ? col_q - POS_BITS'(1) : col_q);
    tok_b.offset = FIELD_BITS'((pos_q != '0) ? pos_q - POS_BITS'(1) : pos_q);
    tok_b.length = FIELD_BITS'(1);

    tok_c.kind   = is_end ? TK_EOF : char_kind(byte_i);
    tok_c.line   = FIELD_BITS'(line_q);
    tok_c.column = FIELD_BITS'(col_q);
    tok_c.offset = FIELD_BITS'(pos_q);
    tok_c.length = is_end ? '0 : FIELD_BITS'(1);

    group_o.tok[0] = pend_a ? tok_a : tok_c;
    group_o.tok[1] = pend_b ? tok_b : tok_c;
    group_o.tok[2] = tok_c;
    group_o.count  = CNT_BITS'(pend_a) + CNT_BITS'(pend_b) + CNT_BITS'(pend_c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      line_q <= POS_BITS'(1);
      col_q  <= POS_BITS'(1);
      pos_q  <= '0;
      soff_q <= '0;
      scol_q <= POS_BITS'(1);
      run_q  <= '0;
      kwb_q  <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      line_q <= line_d;
      col_q  <= col_d;
      pos_q  <= pos_d;
      soff_q <= soff_d;
      scol_q <= scol_d;
      run_q  <= run_d;
      kwb_q  <= kwb_d;
    end
  end

`ifndef ASSERT_OFF
  a_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && kind_i == IN_END |=>
      mode_q == MODE_IDLE && line_q == POS_BITS'(1) && pos_q == '0)
    else $error("scanner not back at start after end of source");

  a_end_gives_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && kind_i == IN_END |-> group_o.count != '0)
    else $error("end of source produced no tokens");

  a_newline_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && kind_i == IN_BYTE && byte_i == CH_NL && line_q != '1 |=>
      col_q == POS_BITS'(1) && line_q == $past(line_q) + POS_BITS'(1))
    else $error("newline did not advance line counter");
`endif

endmodule

// ----- sv/stl_token_queue.sv -----
// result register: holds the token group of one word and hands the tokens out
// one per handshake, marking the final one; depends on stl_pkg and stl_if
`timescale 1ns / 1ps

module stl_token_queue import stl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  stl_group_t  group_i,
  output logic        free_o,
  stl_token_if.source token_o
);

  stl_token_t [MAX_TOKENS-1:0] tok_q;
  logic [CNT_BITS-1:0]         cnt_q;
  logic                        pop;

  assign pop    = token_o.valid && token_o.ready;
  // free once the final token of the group is leaving
  assign free_o = (cnt_q == '0) || (cnt_q == CNT_BITS'(1) && token_o.ready);

  assign token_o.valid        = (cnt_q != '0);
  assign token_o.last         = (cnt_q == CNT_BITS'(1));
  assign token_o.token_kind   = tok_q[0].kind;
  assign token_o.token_line   = tok_q[0].line;
  assign token_o.token_column = tok_q[0].column;
  assign token_o.token_offset = tok_q[0].offset;
  assign token_o.token_length = tok_q[0].length;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= group_i.count;
    end else if (pop) begin
      cnt_q <= cnt_q - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tok_q <= group_i.tok;
    end else if (pop) begin
      for (int i = 0; i < MAX_TOKENS - 1; i++) begin
        tok_q[i] <= tok_q[i+1];
      end
    end
  end

`ifndef ASSERT_OFF
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("token group loaded over undelivered tokens");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i && group_i.count != '0 |=> token_o.valid)
    else $error("loaded tokens not offered");

  a_drain_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && cnt_q > CNT_BITS'(1) |=> token_o.valid)
    else $error("token group cut short");
`endif

endmodule

// ----- sv/source_text_lexer_unit.sv -----
// source text lexer, top level: input register, scan core, token queue
// depends on stl_pkg, stl_if, stl_scan_core and stl_token_queue
//
// char_i takes one word per cycle while ready is high: a source byte (kind 0) or the end marker
// (kind 1). token_o gives tokens with kind, line, start column, byte offset
// and length; last marks the final token caused by one input word.
// An accepted word waits in the input register until the token queue is free,
// is then scanned and loaded, and its tokens are offered from the queue.
// Throughput: one word per cycle while each word gives at most one token and
// the receiver is ready. A word that gives more (up to three) holds the token
// port until they leave one per handshake; the single token port sets the rate.
// Words giving no token (blanks, characters inside a name) leave the port free.
// A stalled receiver holds the token group; one further word waits in the
// input register and char_i.ready drops until the group has drained.
// Reset empties both registers and sets line and column to one. The end
// marker flushes the pending token, gives end of file and restarts the count.
`timescale 1ns / 1ps

module source_text_lexer_unit import stl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  stl_char_if.sink    char_i,
  stl_token_if.source token_o
);

  logic       in_valid_q;
  logic       in_kind_q;
  char_t      in_byte_q;
  logic       step;
  logic       free;
  stl_group_t group;

  assign step         = in_valid_q && free;
  assign char_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (char_i.ready) begin
      in_valid_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.valid && char_i.ready) begin
      in_kind_q <= char_i.kind;
      in_byte_q <= char_i.char_byte;
    end
  end

  stl_scan_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .kind_i  (in_kind_q),
    .byte_i  (in_byte_q),
    .group_o (group)
  );

  stl_token_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step),
    .group_i (group),
    .free_o  (free),
    .token_o (token_o)
  );

endmodule

// ----- verif/source_text_lexer_unit_test.sv -----
// testbench for source_text_lexer_unit: streams source bytes and end markers
// through the char channel and checks every token field by field against a
// local scanner model; depends on stl_pkg, stl_if and the lexer rtl
`timescale 1ns / 1ps

module source_text_lexer_unit_test import stl_pkg::*; ();

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 12;
  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_WORDS = 30;
  localparam int TAIL_CYCLES  = 8;
  localparam int BACKLOG_HOLD = 60;
  localparam int MAX_GAP      = 8;
  localparam int PRINT_LIMIT  = 100;

  typedef struct packed {
    tkind_t kind;
    pos_t   line;
    pos_t   column;
    pos_t   offset;
    pos_t   length;
    logic   last;
  } token_exp_t;

  typedef struct packed {
    logic  kind;
    char_t c;
  } src_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  stl_char_if  char_bus ();
  stl_token_if token_bus ();

  source_text_lexer_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_bus),
    .token_o(token_bus)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // scanner model state
  stl_mode_e            sc_mode;
  pos_t                 sc_line;
  pos_t                 sc_col;
  pos_t                 sc_pos;
  pos_t                 sc_start_off;
  pos_t                 sc_start_col;
  logic [KW_BITS-1:0]   sc_name;
  pos_t                 sc_run;

  token_exp_t step_toks[$];
  token_exp_t tokens_due[$];
  src_word_t  lexeme_words[$];

  int words_sent;
  int mismatch_count;
  int quiet_cycles;
  int rx_hold_req;
  bit tx_steady;
  bit rx_steady;

  // ---------------------------------------------------------------- model

  function automatic pos_t bump(input pos_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic bit digit_ch(input char_t c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit letter_ch(input char_t c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic bit name_ch(input char_t c);
    return letter_ch(c) || digit_ch(c) || (c == "_");
  endfunction

  function automatic bit blank_ch(input char_t c);
    return (c == " ") || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
  endfunction

  // name buffer holds exactly run bytes while run is within the keyword width
  function automatic tkind_t name_kind(input logic [KW_BITS-1:0] nb, input pos_t run);
    tkind_t k;
    k = TK_IDENT;
    if (run <= POS_BITS'(KEYWORD_CHARS)) begin
      case (nb)
        "let":    k = TK_LET;
        "out":    k = TK_OUT;
        "in":     k = TK_IN;
        "if":     k = TK_IF;
        "elif":   k = TK_ELIF;
        "else":   k = TK_ELSE;
        "mod":    k = TK_MOD;
        "int":    k = TK_INT_KW;
        "double": k = TK_DOUBLE;
        "string": k = TK_STRING;
        "bool":   k = TK_BOOL;
        "true":   k = TK_BOOLV;
        "false":  k = TK_BOOLV;
        "and":    k = TK_AND;
        "or":     k = TK_OR;
        default:  k = TK_IDENT;
      endcase
    end
    return k;
  endfunction

  function automatic tkind_t lone_op(input stl_mode_e m);
    case (m)
      MODE_MINUS: return TK_MINUS;
      MODE_EQ:    return TK_ASSIGN;
      MODE_BANG:  return TK_BANG;
      MODE_GT:    return TK_GT;
      MODE_LT:    return TK_LT;
      default:    return TK_SLASH;
    endcase
  endfunction

  task automatic add_tok(input tkind_t k, input pos_t ln, input pos_t cl, input pos_t of,
                         input pos_t le);
    token_exp_t t;
    if (step_toks.size() < MAX_TOKENS) begin
      t.kind   = k;
      t.line   = ln;
      t.column = cl;
      t.offset = of;
      t.length = le;
      t.last   = 1'b0;
      step_toks.insert(step_toks.size(), t);
    end
  endtask

  task automatic add_from_start(input tkind_t k, input pos_t le);
    add_tok(k, sc_line, sc_start_col, sc_start_off, le);
  endtask

  // integer, then the point that led no fraction
  task automatic add_int_dot();
    add_from_start(TK_INT, sc_run);
    add_tok(TK_UNK, sc_line, (sc_col > 1) ? sc_col - 1'b1 : sc_col,
            (sc_pos > 0) ? sc_pos - 1'b1 : '0, POS_BITS'(1));
  endtask

  task automatic scan_restart();
    sc_mode      = MODE_IDLE;
    sc_line      = POS_BITS'(1);
    sc_col       = POS_BITS'(1);
    sc_pos       = '0;
    sc_start_off = '0;
    sc_start_col = POS_BITS'(1);
    sc_name      = '0;
    sc_run       = '0;
  endtask

  task automatic scan_idle(input char_t c);
    tkind_t k;
    k = TK_UNK;
    if (blank_ch(c)) return;
    if (c == CH_NL) begin
      add_tok(TK_EOL, sc_line, sc_col, sc_pos, POS_BITS'(1));
      return;
    end
    sc_start_off = sc_pos;
    sc_start_col = sc_col;
    if (digit_ch(c)) begin
      sc_mode = MODE_NUM;
      sc_run  = POS_BITS'(1);
      return;
    end
    if (letter_ch(c) || (c == "_")) begin
      sc_mode = MODE_IDENT;
      sc_name = KW_BITS'(c);
      sc_run  = POS_BITS'(1);
      return;
    end
    case (c)
      "\"": begin
        sc_mode      = MODE_STR;
        sc_start_off = bump(sc_pos);
        sc_run       = '0;
        return;
      end
      "-": begin sc_mode = MODE_MINUS; return; end
      "=": begin sc_mode = MODE_EQ;    return; end
      "!": begin sc_mode = MODE_BANG;  return; end
      ">": begin sc_mode = MODE_GT;    return; end
      "<": begin sc_mode = MODE_LT;    return; end
      "/": begin sc_mode = MODE_SLASH; return; end
      "+": k = TK_PLUS;
      "*": k = TK_STAR;
      ";": k = TK_SEMI;
      "(": k = TK_LPAREN;
      ")": k = TK_RPAREN;
      "{": k = TK_LBRACE;
      "}": k = TK_RBRACE;
      ",": k = TK_COMMA;
      default: k = TK_UNK;
    endcase
    add_tok(k, sc_line, sc_col, sc_pos, POS_BITS'(1));
  endtask

  task automatic scan_flush();
    case (sc_mode)
      MODE_IDENT:  add_from_start(name_kind(sc_name, sc_run), sc_run);
      MODE_NUM:    add_from_start(TK_INT, sc_run);
      MODE_NUMDOT: add_int_dot();
      MODE_FLOAT:  add_from_start(TK_DEC, sc_run);
      MODE_STR:    add_from_start(TK_STR, sc_run);
      MODE_MINUS, MODE_EQ, MODE_BANG, MODE_GT, MODE_LT, MODE_SLASH:
        add_from_start(lone_op(sc_mode), POS_BITS'(1));
      default: ;
    endcase
    sc_mode = MODE_IDLE;
  endtask

  // works out the tokens one accepted word causes and queues them
  task automatic predict_word(input logic k, input char_t c);
    bit         used;
    bit         paired;
    tkind_t     pk;
    step_toks.delete();
    used = 1'b0;
    if (k == IN_END) begin
      scan_flush();
      add_tok(TK_EOF, sc_line, sc_col, sc_pos, '0);
      scan_restart();
    end else begin
      case (sc_mode)
        MODE_IDENT: begin
          if (name_ch(c)) begin
            if (sc_run < POS_BITS'(KEYWORD_CHARS)) sc_name = {sc_name[KW_BITS-9:0], c};
            sc_run = bump(sc_run);
            used   = 1'b1;
          end else begin
            add_from_start(name_kind(sc_name, sc_run), sc_run);
            sc_mode = MODE_IDLE;
          end
        end
        MODE_NUM: begin
          if (digit_ch(c)) begin
            sc_run = bump(sc_run);
            used   = 1'b1;
          end else if (c == ".") begin
            sc_mode = MODE_NUMDOT;
            used    = 1'b1;
          end else begin
            add_from_start(TK_INT, sc_run);
            sc_mode = MODE_IDLE;
          end
        end
        MODE_NUMDOT: begin
          if (digit_ch(c)) begin
            sc_run  = bump(bump(sc_run));
            sc_mode = MODE_FLOAT;
            used    = 1'b1;
          end else begin
            add_int_dot();
            sc_mode = MODE_IDLE;
          end
        end
        MODE_FLOAT: begin
          if (digit_ch(c)) begin
            sc_run = bump(sc_run);
            used   = 1'b1;
          end else begin
            add_from_start(TK_DEC, sc_run);
            sc_mode = MODE_IDLE;
          end
        end
        MODE_STR: begin
          if (c == "\"") begin
            add_from_start(TK_STR, sc_run);
            sc_mode = MODE_IDLE;
          end else begin
            sc_run = bump(sc_run);
          end
          used = 1'b1;
        end
        MODE_COMMENT: begin
          if (c == CH_NL) sc_mode = MODE_IDLE;
          else used = 1'b1;
        end
        MODE_IDLE: ;
        default: begin
          if ((sc_mode == MODE_SLASH) && (c == "/")) begin
            sc_mode = MODE_COMMENT;
            used    = 1'b1;
          end else begin
            paired = 1'b1;
            pk     = TK_UNK;
            if ((sc_mode == MODE_MINUS) && (c == ">")) pk = TK_ARROW;
            else if ((sc_mode == MODE_EQ) && (c == "=")) pk = TK_EQEQ;
            else if ((sc_mode == MODE_BANG) && (c == "=")) pk = TK_NE;
            else if ((sc_mode == MODE_GT) && (c == "=")) pk = TK_GE;
            else if ((sc_mode == MODE_LT) && (c == "=")) pk = TK_LE;
            else if ((sc_mode == MODE_LT) && (c == "-")) pk = TK_LARROW;
            else paired = 1'b0;
            if (paired) begin
              add_from_start(pk, POS_BITS'(2));
              used = 1'b1;
            end else begin
              add_from_start(lone_op(sc_mode), POS_BITS'(1));
            end
            sc_mode = MODE_IDLE;
          end
        end
      endcase
      if (!used) scan_idle(c);
      if (c == CH_NL) begin
        sc_line = bump(sc_line);
        sc_col  = POS_BITS'(1);
      end else begin
        sc_col = bump(sc_col);
      end
      sc_pos = bump(sc_pos);
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) tokens_due.insert(tokens_due.size(), step_toks[i]);
  endtask

  // ---------------------------------------------------------------- channels

  task automatic send_word(input logic k, input char_t c);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(MAX_GAP, 0);
    if (gap > 0) begin
      char_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    char_bus.valid     <= 1'b1;
    char_bus.kind      <= k;
    char_bus.char_byte <= c;
    @(posedge clk_i);
    while (char_bus.ready !== 1'b1) @(posedge clk_i);
    words_sent++;
    predict_word(k, c);
  endtask

  task automatic send_end_marker();
    send_word(IN_END, char_t'($urandom_range(255, 0)));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(IN_BYTE, s[i]);
  endtask

  // sender goes quiet until every due token has come
  task automatic hold_until_drained();
    char_bus.valid <= 1'b0;
    do @(posedge clk_i); while (tokens_due.size() != 0);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
  endtask

  task automatic check_token();
    token_exp_t want;
    if (tokens_due.size() == 0) begin
      report_mismatch("token with none due, kind", 32'(token_bus.token_kind), 32'd0);
      return;
    end
    want = tokens_due.pop_front();
    if (token_bus.token_kind !== want.kind)
      report_mismatch("token_kind", 32'(token_bus.token_kind), 32'(want.kind));
    if (token_bus.token_line !== want.line)
      report_mismatch("token_line", 32'(token_bus.token_line), 32'(want.line));
    if (token_bus.token_column !== want.column)
      report_mismatch("token_column", 32'(token_bus.token_column), 32'(want.column));
    if (token_bus.token_offset !== want.offset)
      report_mismatch("token_offset", 32'(token_bus.token_offset), 32'(want.offset));
    if (token_bus.token_length !== want.length)
      report_mismatch("token_length", 32'(token_bus.token_length), 32'(want.length));
    if (token_bus.last !== want.last)
      report_mismatch("last", 32'(token_bus.last), 32'(want.last));
  endtask

  task automatic receive_tokens();
    int hold;
    forever begin
      if (rx_hold_req > 0) begin
        hold = rx_hold_req;
        rx_hold_req = 0;
      end else if (rx_steady) begin
        hold = 0;
      end else begin
        hold = $urandom_range(MAX_GAP, 0);
      end
      if (hold > 0) begin
        token_bus.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      token_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (token_bus.valid !== 1'b1) @(posedge clk_i);
      check_token();
    end
  endtask

  always @(posedge clk_i) begin
    if ((char_bus.valid && char_bus.ready) || (token_bus.valid && token_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- lexemes

  function automatic string keyword_text(input int i);
    case (i)
      0:  return "let";
      1:  return "out";
      2:  return "in";
      3:  return "if";
      4:  return "elif";
      5:  return "else";
      6:  return "mod";
      7:  return "int";
      8:  return "double";
      9:  return "string";
      10: return "bool";
      11: return "true";
      12: return "false";
      13: return "and";
      default: return "or";
    endcase
  endfunction

  function automatic string op_text(input int i);
    case (i)
      0:  return "+";
      1:  return "-";
      2:  return "->";
      3:  return "*";
      4:  return "/";
      5:  return "=";
      6:  return "==";
      7:  return "!";
      8:  return "!=";
      9:  return ">";
      10: return ">=";
      11: return "<";
      12: return "<=";
      13: return "<-";
      14: return ";";
      15: return "(";
      16: return ")";
      17: return "{";
      18: return "}";
      default: return ",";
    endcase
  endfunction

  function automatic char_t pick_name_ch();
    int n;
    n = $urandom_range(62, 0);
    if (n < 26) return char_t'("a" + n);
    if (n < 52) return char_t'("A" + n - 26);
    if (n < 62) return char_t'("0" + n - 52);
    return "_";
  endfunction

  function automatic char_t pick_name_start();
    int n;
    n = $urandom_range(52, 0);
    if (n < 26) return char_t'("a" + n);
    if (n < 52) return char_t'("A" + n - 26);
    return "_";
  endfunction

  function automatic char_t pick_digit();
    return char_t'("0" + $urandom_range(9, 0));
  endfunction

  function automatic char_t pick_byte_except(input char_t avoid);
    char_t c;
    do c = char_t'($urandom_range(255, 0)); while (c == avoid);
    return c;
  endfunction

  function automatic char_t pick_blank();
    case ($urandom_range(4, 0))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_VT;
      3: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  task automatic put_byte(input char_t c);
    src_word_t w;
    w.kind = IN_BYTE;
    w.c    = c;
    lexeme_words.insert(lexeme_words.size(), w);
  endtask

  task automatic put_end();
    src_word_t w;
    w.kind = IN_END;
    w.c    = char_t'($urandom_range(255, 0));
    lexeme_words.insert(lexeme_words.size(), w);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic put_separator();
    case ($urandom_range(5, 0))
      0, 1, 2: put_byte(CH_SPACE);
      3:       put_byte(CH_NL);
      4:       put_text(op_text($urandom_range(19, 0)));
      default: ;
    endcase
  endtask

  // one random but mostly well-formed lexeme, then perhaps a separator
  task automatic build_lexeme();
    int pick;
    int n;
    char_t c;
    pick = $urandom_range(99, 0);
    if (pick < 14) begin
      put_text(keyword_text($urandom_range(14, 0)));
      if ($urandom_range(3, 0) == 0) put_byte(pick_name_ch());
    end else if (pick < 26) begin
      n = ($urandom_range(7, 0) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1);
      put_byte(pick_name_start());
      repeat (n - 1) put_byte(pick_name_ch());
    end else if (pick < 34) begin
      repeat ($urandom_range(4, 1)) put_byte(pick_digit());
    end else if (pick < 40) begin
      repeat ($urandom_range(3, 1)) put_byte(pick_digit());
      put_byte(CH_DOT);
      repeat ($urandom_range(3, 1)) put_byte(pick_digit());
    end else if (pick < 44) begin
      // digits and a point that no digit follows
      repeat ($urandom_range(3, 1)) put_byte(pick_digit());
      put_byte(CH_DOT);
      do c = char_t'($urandom_range(255, 0)); while (digit_ch(c));
      put_byte(c);
    end else if (pick < 50) begin
      put_byte(CH_QUOTE);
      repeat ($urandom_range(5, 0)) begin
        if ($urandom_range(3, 0) == 0) put_byte(CH_NL);
        else put_byte(pick_byte_except(CH_QUOTE));
      end
      if ($urandom_range(9, 0) != 0) put_byte(CH_QUOTE);
    end else if (pick < 54) begin
      put_text("//");
      repeat ($urandom_range(6, 0)) put_byte(pick_byte_except(CH_NL));
      put_byte(CH_NL);
    end else if (pick < 74) begin
      put_text(op_text($urandom_range(19, 0)));
    end else if (pick < 80) begin
      put_byte(pick_blank());
    end else if (pick < 86) begin
      put_byte(CH_NL);
    end else if (pick < 95) begin
      put_byte(char_t'($urandom_range(255, 0)));
    end else begin
      put_end();
    end
    if ($urandom_range(2, 0) == 0) put_byte(CH_SPACE);
  endtask

  task automatic play_lexeme();
    src_word_t w;
    while (lexeme_words.size() > 0) begin
      w = lexeme_words.pop_front();
      send_word(w.kind, w.c);
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_edge_cases();
    send_word(IN_BYTE, 8'h00);
    send_word(IN_BYTE, 8'hFF);
    send_text("1.;");          // lone point between integer and semicolon
    send_text("//a\n");        // comment still ends in an end of line
    send_text("strings ");     // too long to be a keyword
    send_text("<-");
    send_text("\"a");          // string left open at end of source
    send_end_marker();
    send_text("7.");           // lone point flushed by the end marker
    send_end_marker();
  endtask

  task automatic test_keywords_and_operators();
    for (int i = 0; i < KW_COUNT; i++) begin
      put_text(keyword_text(i));
      put_separator();
      play_lexeme();
    end
    for (int i = 0; i < 20; i++) begin
      put_text(op_text(i));
      put_separator();
      play_lexeme();
    end
  endtask

  task automatic test_random_stream();
    int first;
    first = words_sent;
    while (words_sent - first < RANDOM_WORDS) begin
      // a stretch in the middle runs with no idling on either side
      tx_steady = (words_sent - first >= 10) && (words_sent - first < 22);
      rx_steady = tx_steady;
      build_lexeme();
      play_lexeme();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // receiver stalls for a long time while words keep coming
  task automatic test_receiver_backlog();
    rx_hold_req = BACKLOG_HOLD;
    tx_steady   = 1'b1;
    repeat (12) begin
      put_text(op_text($urandom_range(19, 0)));
      play_lexeme();
    end
    tx_steady = 1'b0;
  endtask

  task automatic test_sender_pause();
    repeat (3) begin
      repeat (4) begin
        build_lexeme();
        play_lexeme();
      end
      hold_until_drained();
    end
  endtask

  initial begin
    rst_ni             <= 1'b0;
    char_bus.valid     <= 1'b0;
    char_bus.kind      <= IN_BYTE;
    char_bus.char_byte <= '0;
    token_bus.ready    <= 1'b0;
    words_sent     = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    rx_hold_req    = 0;
    tx_steady      = 1'b0;
    rx_steady      = 1'b0;
    scan_restart();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    fork
      receive_tokens();
    join_none

    test_edge_cases();
    test_keywords_and_operators();
    test_random_stream();
    test_receiver_backlog();
    test_sender_pause();

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
